FILE: rtl/core/bhp_pkg.sv
// shared types, constants and codes for the box halo partition unit
// used by bhp_alu, box_halo_partition_unit and bhp_checker; no dependencies
package bhp_pkg;

  // geometry settings
  localparam int AXES       = 3;
  localparam int MAX_AXES   = 3;
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int AX_W       = 2;
  localparam int OPND_W     = FIELD_W + 1;
  localparam int RES_W      = FIELD_W + 2;
  localparam int IN_W       = 9 * FIELD_W;
  localparam int OUT_W      = 6 * FIELD_W;

  // inputs are cut down to the coordinate width first
  localparam logic [FIELD_W-1:0] COORD_MASK =
    (COORD_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << COORD_BITS) - 64'd1);

  // piece codes along one axis
  localparam logic [1:0] PIECE_LEFT   = 2'd0;
  localparam logic [1:0] PIECE_CENTER = 2'd1;
  localparam logic [1:0] PIECE_RIGHT  = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_SUB  = 5'b00100,
    S_BAD  = 5'b01000,
    S_SCAN = 5'b10000
  } state_t;

  // shared adder operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [OPND_W-1:0]   a;
    logic [OPND_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [RES_W-1:0]    sum;
    logic                borrow;
  } alu_rsp_t;

endpackage

FILE: rtl/core/bhp_alu.sv
// shared add/subtract unit for the edge setup of the box halo partition unit
// depends on bhp_pkg
module bhp_alu (
  input  bhp_pkg::alu_req_t req,
  output bhp_pkg::alu_rsp_t rsp
);

  logic [bhp_pkg::RES_W-1:0] ext_a;
  logic [bhp_pkg::RES_W-1:0] ext_b;

  assign ext_a = {1'b0, req.a};
  assign ext_b = {1'b0, req.b};

  // one add or subtract, borrow from the top bit
  always_comb begin
    if (req.op == bhp_pkg::ALU_ADD) begin
      rsp.sum = ext_a + ext_b;
    end else begin
      rsp.sum = ext_a - ext_b;
    end
    rsp.borrow = rsp.sum[bhp_pkg::RES_W-1];
  end

endmodule

FILE: rtl/core/box_halo_partition_unit.sv
// top level of the box halo partition unit: sequencer, edge registers, output stage
// depends on bhp_pkg and bhp_alu
//
// Each input item carries an outer box size, an inner box size and an inner box
// offset on three axes. The unit cuts each axis into left, center and right
// pieces and sends one result item per non-empty product piece, in base-3 order
// with axis 0 most significant; the final one has out_tlast set. An empty outer
// box gives no result; an inner box that leaves the outer box gives one result
// with out_tuser set, out_tlast set and zero data. After an item is taken the
// shared add/subtract unit works out the edges with an add step and a subtract
// step per axis, then the digit counter walks one base-3 code per cycle up to the last
// non-empty piece, at most 27 codes, stalling while the output register is full.
// in_tready is high only while idle, and the last result may still wait in the
// output register when the next item enters.
module box_halo_partition_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // outer_size_0..2, inner_size_0..2, inner_start_0..2, 16 bits each
  input  logic [bhp_pkg::IN_W-1:0]    in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // seg_offset_0..2, seg_extent_0..2, 16 bits each
  output logic [bhp_pkg::OUT_W-1:0]   out_tdata,
  // bad_geometry
  output logic                        out_tuser,
  output logic                        out_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready
);

  localparam int FW = bhp_pkg::FIELD_W;
  localparam int NA = bhp_pkg::MAX_AXES;

  bhp_pkg::state_t         state_r, state_nxt;
  logic [bhp_pkg::AX_W-1:0] ax_r, ax_nxt;
  logic                    empty_r, empty_nxt;
  logic                    bad_r, bad_nxt;
  logic [1:0]              dig_r [NA];
  logic [1:0]              dig_nxt [NA];

  // per-axis edges
  logic [FW-1:0]           outer_r [NA];
  logic [FW-1:0]           size_r  [NA];
  logic [FW-1:0]           start_r [NA];
  logic [FW:0]             hi_r    [NA];
  logic [FW-1:0]           rsize_r [NA];
  logic [2:0]              nz_r    [NA];

  // output stage
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_user_r, out_user_nxt;
  logic [bhp_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  bhp_pkg::alu_req_t       alu_req;
  bhp_pkg::alu_rsp_t       alu_rsp;

  logic                    in_acc;
  logic                    out_free;
  logic                    last_ax;
  logic                    seg_ok;
  logic                    at_end;
  logic [FW-1:0]           seg_off [NA];
  logic [FW-1:0]           seg_ext [NA];
  logic [1:0]              max_dig [NA];
  logic [bhp_pkg::OUT_W-1:0] seg_data;

  assign in_tready  = (state_r == bhp_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign last_ax    = (ax_r == bhp_pkg::AX_W'(bhp_pkg::AXES - 1));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // shared adder: high edge in the add step, right size in the subtract step
  always_comb begin
    if (state_r == bhp_pkg::S_SUB) begin
      alu_req.op = bhp_pkg::ALU_SUB;
      alu_req.a  = {1'b0, outer_r[ax_r]};
      alu_req.b  = hi_r[ax_r];
    end else begin
      alu_req.op = bhp_pkg::ALU_ADD;
      alu_req.a  = {1'b0, start_r[ax_r]};
      alu_req.b  = {1'b0, size_r[ax_r]};
    end
  end

  bhp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // piece selection for the current code
  always_comb begin
    seg_ok = 1'b1;
    at_end = 1'b1;
    for (int a = 0; a < NA; a++) begin
      case (dig_r[a])
        bhp_pkg::PIECE_LEFT: begin
          seg_off[a] = '0;
          seg_ext[a] = start_r[a];
        end
        bhp_pkg::PIECE_CENTER: begin
          seg_off[a] = start_r[a];
          seg_ext[a] = size_r[a];
        end
        bhp_pkg::PIECE_RIGHT: begin
          seg_off[a] = hi_r[a][FW-1:0];
          seg_ext[a] = rsize_r[a];
        end
        default: begin
          seg_off[a] = '0;
          seg_ext[a] = '0;
        end
      endcase
      if (nz_r[a][2]) begin
        max_dig[a] = bhp_pkg::PIECE_RIGHT;
      end else if (nz_r[a][1]) begin
        max_dig[a] = bhp_pkg::PIECE_CENTER;
      end else begin
        max_dig[a] = bhp_pkg::PIECE_LEFT;
      end
      seg_ok = seg_ok && nz_r[a][dig_r[a]];
      at_end = at_end && (dig_r[a] == max_dig[a]);
    end
    seg_data = {seg_ext[2], seg_ext[1], seg_ext[0], seg_off[2], seg_off[1], seg_off[0]};
  end

  // sequencer and output stage
  always_comb begin
    logic carry;
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    empty_nxt     = empty_r;
    bad_nxt       = bad_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    carry         = 1'b1;
    case (state_r)
      bhp_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = bhp_pkg::S_ADD;
          ax_nxt    = '0;
          empty_nxt = 1'b0;
          bad_nxt   = 1'b0;
          for (int a = 0; a < NA; a++) begin
            dig_nxt[a] = bhp_pkg::PIECE_LEFT;
          end
        end
      end
      bhp_pkg::S_ADD: begin
        state_nxt = bhp_pkg::S_SUB;
      end
      bhp_pkg::S_SUB: begin
        empty_nxt = empty_r || (outer_r[ax_r] == '0);
        bad_nxt   = bad_r || alu_rsp.borrow;
        if (last_ax) begin
          if (empty_nxt) begin
            state_nxt = bhp_pkg::S_IDLE;
          end else if (bad_nxt) begin
            state_nxt = bhp_pkg::S_BAD;
          end else begin
            state_nxt = bhp_pkg::S_SCAN;
          end
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = bhp_pkg::S_ADD;
        end
      end
      bhp_pkg::S_BAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_user_nxt  = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = bhp_pkg::S_IDLE;
        end
      end
      bhp_pkg::S_SCAN: begin
        if (out_free) begin
          if (seg_ok) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = at_end;
            out_user_nxt  = 1'b0;
            out_data_nxt  = seg_data;
          end
          if (at_end) begin
            state_nxt = bhp_pkg::S_IDLE;
          end
          // base-3 increment, last axis least significant
          for (int a = NA - 1; a >= 0; a--) begin
            if (carry) begin
              if (dig_r[a] == bhp_pkg::PIECE_RIGHT) begin
                dig_nxt[a] = bhp_pkg::PIECE_LEFT;
              end else begin
                dig_nxt[a] = dig_r[a] + 2'd1;
                carry      = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = bhp_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhp_pkg::S_IDLE;
      ax_r        <= '0;
      empty_r     <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        dig_r[a] <= bhp_pkg::PIECE_LEFT;
      end
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      empty_r     <= empty_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      dig_r       <= dig_nxt;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk) begin
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  // edge registers: capture, then filled axis by axis from the shared adder
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int a = 0; a < NA; a++) begin
        if (a < bhp_pkg::AXES) begin
          outer_r[a] <= in_tdata[a*FW +: FW] & bhp_pkg::COORD_MASK;
          size_r[a]  <= in_tdata[(3+a)*FW +: FW] & bhp_pkg::COORD_MASK;
          start_r[a] <= in_tdata[(6+a)*FW +: FW] & bhp_pkg::COORD_MASK;
        end else begin
          // axis not cut: a single left piece at offset zero, extent one
          outer_r[a] <= FW'(1);
          size_r[a]  <= '0;
          start_r[a] <= FW'(1);
          hi_r[a]    <= '0;
          rsize_r[a] <= '0;
          nz_r[a]    <= 3'b001;
        end
      end
    end
    if (state_r == bhp_pkg::S_ADD) begin
      hi_r[ax_r] <= alu_rsp.sum[FW:0];
    end
    if (state_r == bhp_pkg::S_SUB) begin
      rsize_r[ax_r] <= alu_rsp.sum[FW-1:0];
      nz_r[ax_r]    <= {alu_rsp.sum[FW-1:0] != '0, size_r[ax_r] != '0,
                        start_r[ax_r] != '0};
    end
  end

endmodule

FILE: rtl/core/bhp_checker.sv
// port-level checks for the box halo partition unit, bound to its top level
// depends on bhp_pkg and box_halo_partition_unit
module bhp_port_props (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [bhp_pkg::OUT_W-1:0]   out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready
);

  localparam int FW = bhp_pkg::FIELD_W;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // an error item is alone and carries no geometry
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("error item not last or not zero");

  // a good segment never has a zero extent
  a_ext_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata[3*FW +: FW] != '0) && (out_tdata[4*FW +: FW] != '0) &&
      (out_tdata[5*FW +: FW] != '0))
    else $error("segment with zero extent");

  // the unit is busy with edge setup right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input taken during edge setup");

endmodule

bind box_halo_partition_unit bhp_port_props u_bhp_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
